@@ sv/assert_macros.svh @@
// Assertion helpers for the RTL; included by the sequencer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sdsh_pkg.sv @@
// ----------------------------------------------------------------------------
// sdsh_pkg
// Types, codes and helpers for the SD card SPI host sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package sdsh_pkg;

  localparam int unsigned BlockBytes = 512;
  localparam int unsigned IdxW = 10;

  typedef enum logic [1:0] {
    OP_EXCH  = 2'd0,
    OP_INIT  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RDY_TO   = 3'd1,
    ST_BAD_RESP = 3'd2,
    ST_TOK_TO   = 3'd3,
    ST_WR_REJ   = 3'd4,
    ST_NO_CARD  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CK_NONE = 3'd0,
    CK_MMC  = 3'd1,
    CK_SDV1 = 3'd2,
    CK_SDV2 = 3'd3,
    CK_SDHC = 3'd4
  } card_kind_e;

  // Register indexes on the config port
  localparam logic [2:0] RegReadyWait = 3'd0;
  localparam logic [2:0] RegRespPolls = 3'd1;
  localparam logic [2:0] RegTokPolls  = 3'd2;
  localparam logic [2:0] RegInitRetry = 3'd3;
  localparam logic [2:0] RegResetTry  = 3'd4;
  localparam logic [2:0] RegWakeBytes = 3'd5;

  typedef enum logic [17:0] {
    PH_IDLE   = 18'h00001,
    PH_WAKE   = 18'h00002,
    PH_DESEL  = 18'h00004,
    PH_CREADY = 18'h00008,
    PH_RFAIL  = 18'h00010,
    PH_FRAME  = 18'h00020,
    PH_STUFF  = 18'h00040,
    PH_RESP   = 18'h00080,
    PH_TRAIL  = 18'h00100,
    PH_TOKEN  = 18'h00200,
    PH_RDATA  = 18'h00400,
    PH_RCRC   = 18'h00800,
    PH_DREADY = 18'h01000,
    PH_WTOKEN = 18'h02000,
    PH_WDATA  = 18'h04000,
    PH_WCRC   = 18'h08000,
    PH_WRESP  = 18'h10000,
    PH_FINAL  = 18'h20000
  } phase_e;

  typedef enum logic [4:0] {
    SQ_NONE  = 5'd0,
    SQ_CMD0  = 5'd1,
    SQ_CMD8  = 5'd2,
    SQ_R7    = 5'd3,
    SQ_A55V2 = 5'd4,
    SQ_A41V2 = 5'd5,
    SQ_CMD58 = 5'd6,
    SQ_OCR   = 5'd7,
    SQ_55V1A = 5'd8,
    SQ_41V1A = 5'd9,
    SQ_55V1  = 5'd10,
    SQ_41V1  = 5'd11,
    SQ_CMD1  = 5'd12,
    SQ_CMD16 = 5'd13,
    SQ_RD    = 5'd14,
    SQ_RBLK  = 5'd15,
    SQ_CMD12 = 5'd16,
    SQ_W55   = 5'd17,
    SQ_W23   = 5'd18,
    SQ_WR    = 5'd19
  } seq_e;

  typedef struct packed {
    logic [23:0] ready_wait_limit;
    logic [7:0]  response_polls;
    logic [15:0] token_polls;
    logic [15:0] init_retry_limit;
    logic [7:0]  reset_tries;
    logic [7:0]  wake_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  miso_byte;
    logic [31:0] sector;
    logic [7:0]  block_count;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       chip_select_low;
    logic       exchange_request;
    logic       slow_clock;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       write_byte_taken;
    logic       block_last;
    logic       done_res;
    logic [2:0] status;
    logic [2:0] card_type;
  } out_item_t;

  // Build a 48-bit command frame
  function automatic logic [47:0] make_frame(logic [5:0] cmd, logic [31:0] arg,
                                             logic [7:0] crc);
    make_frame = {2'b01, cmd, arg, crc};
  endfunction

endpackage
`default_nettype wire

@@ sv/sdsh_stream_if.sv @@
// ----------------------------------------------------------------------------
// sdsh_stream_if
// Valid/ready channel carrying one item of a given payload width.
// ----------------------------------------------------------------------------
`default_nettype none
interface sdsh_stream_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/sd_card_spi_host_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// sd_card_spi_host_sequencer_core
// SD card host sequencer in SPI mode: one byte exchange per item.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// in_if     in   opcode, miso_byte, sector, block_count, write_byte
// out_if    out  mosi_byte .. card_type (one result per item)
// apb       in   six limit registers at byte address 4*i
//
// Every item is handled by combinational logic; its result lands in an output register.
// A new item is taken each cycle while the output register is empty or
// being drained, so the sustained rate is one item per clock.
// Reset clears the sequencer to idle, no card, and the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sd_card_spi_host_sequencer_core
  import sdsh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  sdsh_stream_if.sink      in_if,
  sdsh_stream_if.source    out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  cfg_t      cfg;
  out_item_t res;
  out_item_t out_q;
  logic      ovalid_q;
  logic      step;
  logic      busy;
  in_item_t  item;

  assign item = in_item_t'(in_if.payload);

  sdsh_cfg_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  // accept when output register is free or being taken
  assign in_if.ready = !ovalid_q || out_if.ready;
  assign step        = in_if.valid && in_if.ready;

  sdsh_seq_core u_core (
    .clk_i, .rst_ni, .step_i(step), .item_i(item), .cfg_i(cfg),
    .res_o(res), .busy_o(busy)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (step) begin
      ovalid_q <= 1'b1;
    end else if (out_if.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= res;
  end

  assign out_if.valid   = ovalid_q;
  assign out_if.payload = out_q;

  `ASSERT_NEXT(a_fill, clk_i, rst_ni, step, ovalid_q, "result not registered")
  `ASSERT_ALWAYS(a_busy_done, clk_i, rst_ni,
    !(ovalid_q && out_q.done_res && out_q.exchange_request), "done with exchange")
  `ASSERT_ALWAYS(a_rd_wr, clk_i, rst_ni,
    !(ovalid_q && out_q.read_valid && out_q.write_byte_taken), "read and write together")
  `ASSERT_NEXT(a_idle_done, clk_i, rst_ni, step && res.done_res, !busy, "done while busy")
endmodule
`default_nettype wire

@@ sv/sdsh_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sdsh_cfg_regs
// APB-style register file for the poll, wait and retry limits and the wake byte count.
// ----------------------------------------------------------------------------
`default_nettype none
module sdsh_cfg_regs
  import sdsh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);
  cfg_t        cfg_q;
  logic [2:0]  idx;
  logic        wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ready_wait_limit <= 24'hFFFFFF;
      cfg_q.response_polls   <= 8'd32;
      cfg_q.token_polls      <= 16'hFFFF;
      cfg_q.init_retry_limit <= 16'hFFFE;
      cfg_q.reset_tries      <= 8'd21;
      cfg_q.wake_bytes       <= 8'd10;
    end else if (wr) begin
      case (idx)
        RegReadyWait: cfg_q.ready_wait_limit <= pwdata[23:0];
        RegRespPolls: cfg_q.response_polls   <= pwdata[7:0];
        RegTokPolls:  cfg_q.token_polls      <= pwdata[15:0];
        RegInitRetry: cfg_q.init_retry_limit <= pwdata[15:0];
        RegResetTry:  cfg_q.reset_tries      <= pwdata[7:0];
        RegWakeBytes: cfg_q.wake_bytes       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      RegReadyWait: prdata = {8'd0, cfg_q.ready_wait_limit};
      RegRespPolls: prdata = {24'd0, cfg_q.response_polls};
      RegTokPolls:  prdata = {16'd0, cfg_q.token_polls};
      RegInitRetry: prdata = {16'd0, cfg_q.init_retry_limit};
      RegResetTry:  prdata = {24'd0, cfg_q.reset_tries};
      RegWakeBytes: prdata = {24'd0, cfg_q.wake_bytes};
      default:      prdata = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

@@ sv/sdsh_seq_core.sv @@
// ----------------------------------------------------------------------------
// sdsh_seq_core
// Sequencer state and next-state logic; one item per accepted cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sdsh_seq_core
  import sdsh_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  in_item_t       item_i,
  input  cfg_t           cfg_i,
  output out_item_t      res_o,
  output logic           busy_o
);
  phase_e      phase_q, phase_d;
  seq_e        seq_q, seq_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [23:0] wait_q, wait_d;
  logic [15:0] retry_q, retry_d;
  logic [2:0]  kind_q, kind_d, pkind_q, pkind_d;
  logic [31:0] addr_q, addr_d, reply_q, reply_d;
  logic [7:0]  left_q, left_d, lastr_q, lastr_d, tok_q, tok_d;
  logic [47:0] frame_q, frame_d;
  logic [1:0]  op_q, op_d;
  logic [2:0]  fst_q, fst_d;
  logic        multi_q, multi_d, rf_q, rf_d;
  out_item_t   r;

  // limits of zero act as one
  logic [23:0] rwl;
  logic [7:0]  rpl;
  logic [15:0] tpl;
  assign rwl = (cfg_i.ready_wait_limit == 24'd0) ? 24'd1 : cfg_i.ready_wait_limit;
  assign rpl = (cfg_i.response_polls == 8'd0) ? 8'd1 : cfg_i.response_polls;
  assign tpl = (cfg_i.token_polls == 16'd0) ? 16'd1 : cfg_i.token_polls;

  logic [7:0]  fb;
  logic [2:0]  fsel;
  logic [2:0]  fail;
  logic [23:0] winc;
  logic [7:0]  wst;
  logic        wdone;
  assign fail = rf_q ? ST_RDY_TO : ST_BAD_RESP;
  assign winc = wait_q + 24'd1;

  always_comb begin
    phase_d = phase_q; seq_d = seq_q; idx_d = idx_q; wait_d = wait_q;
    retry_d = retry_q; kind_d = kind_q; pkind_d = pkind_q; addr_d = addr_q;
    reply_d = reply_q; left_d = left_q; lastr_d = lastr_q; tok_d = tok_q;
    frame_d = frame_q; op_d = op_q; fst_d = fst_q; multi_d = multi_q; rf_d = rf_q;
    r = '0;
    fsel = 3'd0; fb = 8'hFF; wst = 8'd0; wdone = 1'b0;

    if (item_i.opcode != OP_EXCH) begin
      if (phase_q == PH_IDLE) begin
        op_d = item_i.opcode; fst_d = ST_OK;
        if (item_i.opcode == OP_INIT) begin
          kind_d = CK_NONE; pkind_d = CK_NONE; idx_d = '0; phase_d = PH_WAKE;
          r.mosi_byte = 8'hFF; r.exchange_request = 1'b1;
        end else if (kind_q == CK_NONE) begin
          r.done_res = 1'b1; r.status = ST_NO_CARD;
        end else if (item_i.block_count == 8'd0) begin
          r.done_res = 1'b1; r.status = ST_OK;
        end else begin
          logic [31:0] a;
          logic        m;
          logic [5:0]  c;
          a = (kind_q == CK_SDHC) ? item_i.sector : {item_i.sector[22:0], 9'd0};
          m = (item_i.block_count != 8'd1);
          addr_d = a; left_d = item_i.block_count; multi_d = m;
          if (item_i.opcode == OP_READ) begin
            c = m ? 6'd18 : 6'd17; seq_d = SQ_RD;
          end else if (!m) begin
            c = 6'd24; seq_d = SQ_WR;
          end else if (kind_q != CK_MMC) begin
            c = 6'd55; a = 32'd0; seq_d = SQ_W55;
          end else begin
            c = 6'd25; seq_d = SQ_WR;
          end
          frame_d = make_frame(c, a, 8'h01); rf_d = 1'b0; phase_d = PH_DESEL;
          r.mosi_byte = 8'hFF; r.exchange_request = 1'b1;
        end
      end
    end else begin
      case (phase_q)
        PH_WAKE: begin
          idx_d = idx_q + 1'b1;
          if (idx_d < {2'd0, cfg_i.wake_bytes}) begin
            r.mosi_byte = 8'hFF; r.exchange_request = 1'b1;
          end else begin
            retry_d = '0; frame_d = make_frame(6'd0, 32'd0, 8'h95); seq_d = SQ_CMD0;
            rf_d = 1'b0; phase_d = PH_DESEL;
            r.mosi_byte = 8'hFF; r.exchange_request = 1'b1;
          end
        end
        PH_DESEL: begin
          phase_d = PH_CREADY; wait_d = '0;
          r.mosi_byte = 8'hFF; r.chip_select_low = 1'b1; r.exchange_request = 1'b1;
        end
        PH_CREADY: begin
          r.exchange_request = 1'b1; r.mosi_byte = 8'hFF;
          if (item_i.miso_byte == 8'hFF) begin
            phase_d = PH_FRAME; idx_d = '0; r.mosi_byte = frame_q[47:40];
            r.chip_select_low = 1'b1;
          end else begin
            wait_d = winc;
            if (winc >= rwl) phase_d = PH_RFAIL;
            else r.chip_select_low = 1'b1;
          end
        end
        PH_FRAME: begin
          idx_d = idx_q + 1'b1;
          r.exchange_request = 1'b1; r.chip_select_low = 1'b1; r.mosi_byte = 8'hFF;
          if (idx_d < 10'd6) begin
            fsel = idx_d[2:0];
            case (fsel)
              3'd1: r.mosi_byte = frame_q[39:32];
              3'd2: r.mosi_byte = frame_q[31:24];
              3'd3: r.mosi_byte = frame_q[23:16];
              3'd4: r.mosi_byte = frame_q[15:8];
              3'd5: r.mosi_byte = frame_q[7:0];
              default: r.mosi_byte = frame_q[47:40];
            endcase
          end else if (frame_q[47:40] == 8'h4C) phase_d = PH_STUFF;
          else begin
            phase_d = PH_RESP; wait_d = '0;
          end
        end
        PH_STUFF: begin
          phase_d = PH_RESP; wait_d = '0;
          r.mosi_byte = 8'hFF; r.chip_select_low = 1'b1; r.exchange_request = 1'b1;
        end
        PH_TRAIL: begin
          reply_d = {reply_q[23:0], item_i.miso_byte};
          idx_d = idx_q + 1'b1;
          if (idx_d < 10'd4) begin
            r.mosi_byte = 8'hFF; r.chip_select_low = 1'b1; r.exchange_request = 1'b1;
          end else if (seq_q == SQ_R7) begin
            if (reply_d[15:0] == 16'h01AA) begin
              retry_d = '0; frame_d = make_frame(6'd55, 32'd0, 8'h01);
              seq_d = SQ_A55V2; rf_d = 1'b0; phase_d = PH_DESEL;
              r.mosi_byte = 8'hFF; r.exchange_request = 1'b1;
            end else begin
              fst_d = ST_BAD_RESP; phase_d = PH_FINAL;
              r.mosi_byte = 8'hFF; r.exchange_request = 1'b1;
            end
          end else begin
            kind_d = reply_d[30] ? CK_SDHC : CK_SDV2;
            fst_d = ST_OK; phase_d = PH_FINAL;
            r.mosi_byte = 8'hFF; r.exchange_request = 1'b1;
          end
        end
        PH_TOKEN: begin
          r.mosi_byte = 8'hFF; r.exchange_request = 1'b1;
          if (item_i.miso_byte == 8'hFE) begin
            phase_d = PH_RDATA; idx_d = '0; r.chip_select_low = 1'b1;
          end else begin
            wait_d = winc;
            if (winc[15:0] >= tpl || winc[23:16] != 8'd0) begin
              fst_d = ST_TOK_TO;
              if (multi_q) begin
                frame_d = make_frame(6'd12, 32'd0, 8'h01); seq_d = SQ_CMD12;
                rf_d = 1'b0; phase_d = PH_DESEL;
              end else phase_d = PH_FINAL;
            end else r.chip_select_low = 1'b1;
          end
        end
        PH_RDATA: begin
          r.read_byte = item_i.miso_byte; r.read_valid = 1'b1;
          idx_d = idx_q + 1'b1;
          if ({1'b0, idx_d} >= 11'(BlockBytes)) begin
            r.block_last = 1'b1; phase_d = PH_RCRC; idx_d = '0;
          end
          r.mosi_byte = 8'hFF; r.chip_select_low = 1'b1; r.exchange_request = 1'b1;
        end
        PH_RCRC: begin
          idx_d = idx_q + 1'b1;
          r.mosi_byte = 8'hFF; r.exchange_request = 1'b1;
          if (idx_d < 10'd2) r.chip_select_low = 1'b1;
          else begin
            left_d = left_q - 8'd1;
            if (left_d != 8'd0) begin
              seq_d = SQ_RBLK; wait_d = '0; phase_d = PH_TOKEN; r.chip_select_low = 1'b1;
            end else begin
              fst_d = ST_OK;
              if (multi_q) begin
                frame_d = make_frame(6'd12, 32'd0, 8'h01); seq_d = SQ_CMD12;
                rf_d = 1'b0; phase_d = PH_DESEL;
              end else phase_d = PH_FINAL;
            end
          end
        end
        PH_DREADY: begin
          r.mosi_byte = 8'hFF; r.chip_select_low = 1'b1; r.exchange_request = 1'b1;
          if (item_i.miso_byte == 8'hFF) begin
            phase_d = PH_WTOKEN; r.mosi_byte = tok_q;
          end else begin
            wait_d = winc;
            if (winc >= rwl) begin
              wdone = 1'b1; wst = 8'(ST_RDY_TO);
            end
          end
        end
        PH_WTOKEN: begin
          if (tok_q == 8'hFD) begin
            wdone = 1'b1; wst = 8'(ST_OK);
          end else begin
            phase_d = PH_WDATA; idx_d = '0;
            r.mosi_byte = item_i.write_byte; r.chip_select_low = 1'b1;
            r.exchange_request = 1'b1; r.write_byte_taken = 1'b1;
          end
        end
        PH_WDATA: begin
          idx_d = idx_q + 1'b1;
          r.chip_select_low = 1'b1; r.exchange_request = 1'b1;
          if ({1'b0, idx_d} < 11'(BlockBytes)) begin
            r.mosi_byte = item_i.write_byte; r.write_byte_taken = 1'b1;
            if ({1'b0, idx_d} == 11'(BlockBytes - 1)) r.block_last = 1'b1;
          end else begin
            phase_d = PH_WCRC; idx_d = '0; r.mosi_byte = 8'hFF;
          end
        end
        PH_WCRC: begin
          idx_d = idx_q + 1'b1;
          r.mosi_byte = 8'hFF; r.chip_select_low = 1'b1; r.exchange_request = 1'b1;
          if (idx_d >= 10'd2) phase_d = PH_WRESP;
        end
        PH_WRESP: begin
          wdone = 1'b1;
          wst = (item_i.miso_byte[4:0] == 5'h05) ? 8'(ST_OK) : 8'(ST_WR_REJ);
        end
        PH_FINAL: begin
          phase_d = PH_IDLE; r.done_res = 1'b1; r.status = fst_q;
        end
        PH_RFAIL, PH_RESP: begin
          logic       take;
          logic [7:0] r1;
          logic [23:0] rinc;
          take = 1'b0; r1 = item_i.miso_byte; rinc = 24'({8'd0, wait_q[7:0]} + 24'd1);
          if (phase_q == PH_RFAIL) begin
            rf_d = 1'b1; take = 1'b1; r1 = 8'hFF;
          end else begin
            if (!item_i.miso_byte[7]) take = 1'b1;
            else begin
              wait_d = rinc;
              if (rinc[8:0] >= {1'b0, rpl}) take = 1'b1;
            end
            if (!take) begin
              r.mosi_byte = 8'hFF; r.chip_select_low = 1'b1; r.exchange_request = 1'b1;
            end
          end
          if (take) begin
            logic       sc;
            logic [5:0] c;
            logic [31:0] a;
            logic [7:0] crc;
            logic [2:0] fin;
            logic       fn, tr;
            logic       rfn;
            rfn = (phase_q == PH_RFAIL) ? 1'b1 : rf_q;
            sc = 1'b0; c = 6'd0; a = 32'd0; crc = 8'h01; fin = ST_OK; fn = 1'b0;
            tr = 1'b0;
            lastr_d = r1;
            r.mosi_byte = 8'hFF; r.exchange_request = 1'b1;
            case (seq_q)
              SQ_CMD0: begin
                if (r1 == 8'd1) begin
                  sc = 1'b1; c = 6'd8; a = 32'h1AA; crc = 8'h87; seq_d = SQ_CMD8;
                end else begin
                  retry_d = retry_q + 16'd1;
                  if (retry_d >= {8'd0, cfg_i.reset_tries}) begin
                    fn = 1'b1; fin = ST_NO_CARD;
                  end else begin
                    sc = 1'b1; c = 6'd0; crc = 8'h95; seq_d = SQ_CMD0;
                  end
                end
              end
              SQ_CMD8: begin
                if (r1 == 8'd1) begin
                  tr = 1'b1; seq_d = SQ_R7;
                end else begin
                  sc = 1'b1; c = 6'd55; seq_d = SQ_55V1A;
                end
              end
              SQ_A55V2: begin
                sc = 1'b1; c = 6'd41; a = 32'h40000000; seq_d = SQ_A41V2;
              end
              SQ_55V1A: begin
                sc = 1'b1; c = 6'd41; seq_d = SQ_41V1A;
              end
              SQ_55V1: begin
                sc = 1'b1; c = 6'd41; seq_d = SQ_41V1;
              end
              SQ_A41V2, SQ_41V1, SQ_CMD1: begin
                if (r1 == 8'd0) begin
                  sc = 1'b1;
                  if (seq_q == SQ_A41V2) begin
                    c = 6'd58; seq_d = SQ_CMD58;
                  end else begin
                    c = 6'd16; a = 32'(BlockBytes); seq_d = SQ_CMD16;
                  end
                end else if (retry_q >= cfg_i.init_retry_limit) begin
                  fn = 1'b1; fin = rfn ? ST_RDY_TO : ST_BAD_RESP;
                end else begin
                  retry_d = retry_q + 16'd1; sc = 1'b1;
                  if (seq_q == SQ_A41V2) begin
                    c = 6'd55; seq_d = SQ_A55V2;
                  end else if (seq_q == SQ_41V1) begin
                    c = 6'd55; seq_d = SQ_55V1;
                  end else begin
                    c = 6'd1; seq_d = SQ_CMD1;
                  end
                end
              end
              SQ_CMD58: begin
                if (r1 == 8'd0) begin
                  tr = 1'b1; seq_d = SQ_OCR;
                end else begin
                  fn = 1'b1; fin = rfn ? ST_RDY_TO : ST_BAD_RESP;
                end
              end
              SQ_41V1A: begin
                retry_d = '0; sc = 1'b1;
                if (r1 <= 8'd1) begin
                  pkind_d = CK_SDV1; c = 6'd55; seq_d = SQ_55V1;
                end else begin
                  pkind_d = CK_MMC; c = 6'd1; seq_d = SQ_CMD1;
                end
              end
              SQ_CMD16: begin
                fn = 1'b1;
                if (r1 == 8'd0) begin
                  kind_d = pkind_q; fin = ST_OK;
                end else fin = rfn ? ST_RDY_TO : ST_BAD_RESP;
              end
              SQ_RD: begin
                if (r1 != 8'd0) begin
                  fn = 1'b1; fin = rfn ? ST_RDY_TO : ST_BAD_RESP;
                end else begin
                  seq_d = SQ_RBLK; wait_d = '0; phase_d = PH_TOKEN;
                  r.chip_select_low = 1'b1;
                end
              end
              SQ_CMD12: begin
                fn = 1'b1; fin = fst_q;
              end
              SQ_W55: begin
                sc = 1'b1; c = 6'd23; a = {24'd0, left_q}; seq_d = SQ_W23;
              end
              SQ_W23: begin
                sc = 1'b1; c = 6'd25; a = addr_q; seq_d = SQ_WR;
              end
              SQ_WR: begin
                if (r1 != 8'd0) begin
                  fn = 1'b1; fin = rfn ? ST_RDY_TO : ST_BAD_RESP;
                end else begin
                  tok_d = multi_q ? 8'hFC : 8'hFE; wait_d = '0; phase_d = PH_DREADY;
                  r.chip_select_low = 1'b1;
                end
              end
              default: begin
                fn = 1'b1; fin = ST_BAD_RESP;
              end
            endcase
            if (sc) begin
              frame_d = make_frame(c, a, crc); rf_d = 1'b0; phase_d = PH_DESEL;
            end
            if (tr) begin
              reply_d = '0; idx_d = '0; phase_d = PH_TRAIL; r.chip_select_low = 1'b1;
            end
            if (fn) begin
              fst_d = fin; phase_d = PH_FINAL;
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase

      // shared tail after a data block write, a stop token or a ready timeout
      if (wdone) begin
        r.mosi_byte = 8'hFF; r.exchange_request = 1'b1; r.chip_select_low = 1'b0;
        if (tok_q == 8'hFD) begin
          fst_d = (fst_q != ST_OK) ? fst_q : wst[2:0]; phase_d = PH_FINAL;
        end else if (!multi_q) begin
          fst_d = wst[2:0]; phase_d = PH_FINAL;
        end else begin
          r.chip_select_low = 1'b1; wait_d = '0; phase_d = PH_DREADY;
          if (wst != 8'd0) begin
            fst_d = wst[2:0]; tok_d = 8'hFD;
          end else begin
            left_d = left_q - 8'd1;
            tok_d = (left_d != 8'd0) ? 8'hFC : 8'hFD;
          end
        end
      end
    end

    r.slow_clock = (phase_d != PH_IDLE) && (op_d == OP_INIT);
    r.card_type  = kind_d;
  end

  assign res_o  = r;
  assign busy_o = (phase_q != PH_IDLE);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; seq_q <= SQ_NONE; idx_q <= '0; wait_q <= '0;
      retry_q <= '0; kind_q <= CK_NONE; pkind_q <= CK_NONE; addr_q <= '0;
      reply_q <= '0; left_q <= '0; lastr_q <= 8'hFF; tok_q <= '0;
      frame_q <= '0; op_q <= OP_EXCH; fst_q <= ST_OK; multi_q <= 1'b0; rf_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d; seq_q <= seq_d; idx_q <= idx_d; wait_q <= wait_d;
      retry_q <= retry_d; kind_q <= kind_d; pkind_q <= pkind_d; addr_q <= addr_d;
      reply_q <= reply_d; left_q <= left_d; lastr_q <= lastr_d; tok_q <= tok_d;
      frame_q <= frame_d; op_q <= op_d; fst_q <= fst_d; multi_q <= multi_d;
      rf_q <= rf_d;
    end
  end
endmodule
`default_nettype wire
